[hw/rtl/rpp_pkg.sv]
`timescale 1ns / 1ps

package rpp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;

    localparam int COORD_W = 15;
    localparam int ANGLE_W = 16;
    localparam int RES_W   = 17;
    localparam int DIFF_W  = 16;
    localparam int CRD_W   = 32;
    localparam int TRIG_W  = 18;
    localparam int PROD_W  = 34;
    localparam int SUM_W   = 35;
    localparam int FRAC_W  = 16;
    localparam int RND_W   = SUM_W - FRAC_W;
    localparam int PRE_W   = RND_W + 1;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    // cordic start value: 1/gain in q30
    localparam logic signed [CRD_W-1:0] GAIN_Q30 = 32'sd652032874;

    localparam logic signed [CRD_W-1:0] Q30_RND  = 32'sd8192;
    localparam int                      Q30_SHR  = 14;
    localparam logic signed [CRD_W-1:0] TRIG_MAX = 32'sd65536;
    localparam logic signed [CRD_W-1:0] TRIG_MIN = -32'sd65536;

    localparam logic signed [SUM_W-1:0] HALF_POS = 35'sd32768;
    localparam logic signed [SUM_W-1:0] HALF_NEG = 35'sd32767;

    localparam logic signed [PRE_W-1:0] RES_MAX = 20'sd65535;
    localparam logic signed [PRE_W-1:0] RES_MIN = -20'sd65536;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_geo;

    typedef struct packed {
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
        logic [1:0]              quad;
    } t_crd;

    typedef struct packed {
        logic signed [RND_W-1:0]   rx;
        logic signed [RND_W-1:0]   ry;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_rnd;

    // arctangent of 2^-idx, 2^32 units per turn
    function automatic logic signed [CRD_W-1:0] rpp_atan(input int idx);
        logic signed [CRD_W-1:0] v;
        case (idx)
            0:  v = 32'sh20000000;
            1:  v = 32'sh12E4051E;
            2:  v = 32'sh09FB385B;
            3:  v = 32'sh051111D4;
            4:  v = 32'sh028B0D43;
            5:  v = 32'sh0145D7E1;
            6:  v = 32'sh00A2F61E;
            7:  v = 32'sh00517C55;
            8:  v = 32'sh0028BE53;
            9:  v = 32'sh00145F2F;
            10: v = 32'sh000A2F98;
            11: v = 32'sh000517CC;
            12: v = 32'sh00028BE6;
            13: v = 32'sh000145F3;
            14: v = 32'sh0000A2FA;
            15: v = 32'sh0000517D;
            16: v = 32'sh000028BE;
            17: v = 32'sh0000145F;
            18: v = 32'sh00000A30;
            19: v = 32'sh00000518;
            20: v = 32'sh0000028C;
            21: v = 32'sh00000146;
            22: v = 32'sh000000A3;
            23: v = 32'sh00000051;
            24: v = 32'sh00000029;
            25: v = 32'sh00000014;
            26: v = 32'sh0000000A;
            27: v = 32'sh00000005;
            28: v = 32'sh00000003;
            29: v = 32'sh00000001;
            30: v = 32'sh00000001;
            default: v = 32'sh00000000;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/point_rotation_about_pivot_core.sv]
`timescale 1ns / 1ps
// channel   dir  width  content (lowest bit up)
// s_axis    in   80     point_x[14:0] point_y[29:15] pivot_x[44:30] pivot_y[59:45]
//                       turn_angle[75:60], zero pad
// m_axis    out  40     rotated_x[16:0] rotated_y[33:17], zero pad
//
// one point per cycle sustained while m_axis keeps taking results; registers in order
// (input stage, one register per cordic step, fold, multiply, round, output)
// i_rst_n is synchronous and active low, it clears the valid bits only
// every stage holds its item while its successor cannot take it, empty stages
// keep loading, so input is taken while a result waits on m_axis

module point_rotation_about_pivot_core import rpp_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // point_x, point_y, pivot_x, pivot_y, turn_angle, pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // rotated_x, rotated_y, pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic                    w_front_v;
    logic                    w_front_rdy;
    t_crd                    w_front_crd;
    t_geo                    w_front_geo;
    logic                    w_cord_v;
    logic                    w_cord_rdy;
    t_crd                    w_cord_crd;
    t_geo                    w_cord_geo;
    logic                    w_mix_v;
    logic                    w_mix_rdy;
    t_rnd                    w_mix_rnd;
    logic                    w_out_rdy;
    logic signed [PRE_W-1:0] w_pre_x;
    logic signed [PRE_W-1:0] w_pre_y;
    logic signed [RES_W-1:0] n_out_x;
    logic signed [RES_W-1:0] n_out_y;
    logic                    r_out_v;
    logic signed [RES_W-1:0] r_out_x;
    logic signed [RES_W-1:0] r_out_y;

    rpp_front #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_point_x   (i_s_axis_tdata[14:0]),
        .i_point_y   (i_s_axis_tdata[29:15]),
        .i_pivot_x   (i_s_axis_tdata[44:30]),
        .i_pivot_y   (i_s_axis_tdata[59:45]),
        .i_turn_angle(i_s_axis_tdata[75:60]),
        .o_valid     (w_front_v),
        .i_ready     (w_front_rdy),
        .o_crd       (w_front_crd),
        .o_geo       (w_front_geo)
    );

    rpp_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_front_v),
        .o_ready(w_front_rdy),
        .i_crd  (w_front_crd),
        .i_geo  (w_front_geo),
        .o_valid(w_cord_v),
        .i_ready(w_cord_rdy),
        .o_crd  (w_cord_crd),
        .o_geo  (w_cord_geo)
    );

    rpp_mix u_mix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_cord_v),
        .o_ready(w_cord_rdy),
        .i_crd  (w_cord_crd),
        .i_geo  (w_cord_geo),
        .o_valid(w_mix_v),
        .i_ready(w_mix_rdy),
        .o_rnd  (w_mix_rnd)
    );

    // pivot added back, then saturated to the result width
    assign w_pre_x = {w_mix_rnd.rx[RND_W-1], w_mix_rnd.rx}
                   + {{(PRE_W-COORD_W){w_mix_rnd.px[COORD_W-1]}}, w_mix_rnd.px};
    assign w_pre_y = {w_mix_rnd.ry[RND_W-1], w_mix_rnd.ry}
                   + {{(PRE_W-COORD_W){w_mix_rnd.py[COORD_W-1]}}, w_mix_rnd.py};

    always_comb begin
        if (w_pre_x > RES_MAX) begin
            n_out_x = RES_W'(RES_MAX);
        end else if (w_pre_x < RES_MIN) begin
            n_out_x = RES_W'(RES_MIN);
        end else begin
            n_out_x = w_pre_x[RES_W-1:0];
        end
        if (w_pre_y > RES_MAX) begin
            n_out_y = RES_W'(RES_MAX);
        end else if (w_pre_y < RES_MIN) begin
            n_out_y = RES_W'(RES_MIN);
        end else begin
            n_out_y = w_pre_y[RES_W-1:0];
        end
    end

    assign w_out_rdy = !r_out_v || i_m_axis_tready;
    assign w_mix_rdy = w_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_v <= w_mix_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_mix_v) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {{(M_TDATA_W-2*RES_W){1'b0}}, r_out_y, r_out_x};

`ifndef NO_ASSERTIONS
    // input backs up only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled while the pipeline has room");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_mix_v))
        else $error("result appeared without an item in the round stage");
`endif

endmodule

[hw/rtl/rpp_front.sv]
`timescale 1ns / 1ps

module rpp_front import rpp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_pivot_x,
    input  logic signed [COORD_W-1:0] i_pivot_y,
    input  logic [ANGLE_W-1:0]        i_turn_angle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_crd                      o_crd,
    output t_geo                      o_geo
);

    logic [CRD_W-1:0] w_z32;
    t_crd             n_crd;
    t_geo             n_geo;
    logic             r_valid;
    t_crd             r_crd;
    t_geo             r_geo;

    // angle scaled to 2^32 per turn, bits above ANGLE_BITS fall off the top
    assign w_z32 = {{(CRD_W-ANGLE_W){1'b0}}, i_turn_angle} << (CRD_W - ANGLE_BITS);

    always_comb begin
        n_crd.x    = GAIN_Q30;
        n_crd.y    = '0;
        n_crd.z    = {2'b00, w_z32[CRD_W-3:0]};
        n_crd.quad = w_z32[CRD_W-1:CRD_W-2];
        n_geo.dx   = {i_point_x[COORD_W-1], i_point_x} - {i_pivot_x[COORD_W-1], i_pivot_x};
        n_geo.dy   = {i_point_y[COORD_W-1], i_point_y} - {i_pivot_y[COORD_W-1], i_pivot_y};
        n_geo.px   = i_pivot_x;
        n_geo.py   = i_pivot_y;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_crd <= n_crd;
            r_geo <= n_geo;
        end
    end

    assign o_valid = r_valid;
    assign o_crd   = r_crd;
    assign o_geo   = r_geo;

endmodule

[hw/rtl/rpp_cordic.sv]
`timescale 1ns / 1ps

module rpp_cordic import rpp_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_crd i_crd,
    input  t_geo i_geo,
    output logic o_valid,
    input  logic i_ready,
    output t_crd o_crd,
    output t_geo o_geo
);

    logic r_v   [CORDIC_STEPS];
    t_crd r_crd [CORDIC_STEPS];
    t_geo r_geo [CORDIC_STEPS];
    logic w_v   [CORDIC_STEPS+1];
    t_crd w_crd [CORDIC_STEPS+1];
    t_geo w_geo [CORDIC_STEPS+1];
    logic w_rdy [CORDIC_STEPS+1];

    assign w_v[0]              = i_valid;
    assign w_crd[0]            = i_crd;
    assign w_geo[0]            = i_geo;
    assign w_rdy[CORDIC_STEPS] = i_ready;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        t_crd                    n_crd;
        logic signed [CRD_W-1:0] w_xs;
        logic signed [CRD_W-1:0] w_ys;

        assign w_xs = w_crd[k].x >>> k;
        assign w_ys = w_crd[k].y >>> k;

        always_comb begin
            n_crd = w_crd[k];
            if (!w_crd[k].z[CRD_W-1]) begin
                n_crd.x = w_crd[k].x - w_ys;
                n_crd.y = w_crd[k].y + w_xs;
                n_crd.z = w_crd[k].z - rpp_atan(k);
            end else begin
                n_crd.x = w_crd[k].x + w_ys;
                n_crd.y = w_crd[k].y - w_xs;
                n_crd.z = w_crd[k].z + rpp_atan(k);
            end
        end

        // a stage may load when empty or when its successor takes its item
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_v[k]) begin
                r_crd[k] <= n_crd;
                r_geo[k] <= w_geo[k];
            end
        end

        assign w_v[k+1]   = r_v[k];
        assign w_crd[k+1] = r_crd[k];
        assign w_geo[k+1] = r_geo[k];
    end

    assign o_ready = w_rdy[0];
    assign o_valid = w_v[CORDIC_STEPS];
    assign o_crd   = w_crd[CORDIC_STEPS];
    assign o_geo   = w_geo[CORDIC_STEPS];

endmodule

[hw/rtl/rpp_mix.sv]
`timescale 1ns / 1ps

module rpp_mix import rpp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_crd i_crd,
    input  t_geo i_geo,
    output logic o_valid,
    input  logic i_ready,
    output t_rnd o_rnd
);

    // stage a: quadrant fold, q30 to q16, clamp
    logic signed [CRD_W-1:0]  w_c;
    logic signed [CRD_W-1:0]  w_s;
    logic signed [CRD_W-1:0]  w_c16;
    logic signed [CRD_W-1:0]  w_s16;
    logic signed [TRIG_W-1:0] n_c;
    logic signed [TRIG_W-1:0] n_s;
    logic                     r_va;
    logic                     w_rdy_a;
    logic signed [TRIG_W-1:0] r_c;
    logic signed [TRIG_W-1:0] r_s;
    t_geo                     r_geo_a;

    // stage b: products
    logic signed [PROD_W-1:0]  n_p_xc;
    logic signed [PROD_W-1:0]  n_p_ys;
    logic signed [PROD_W-1:0]  n_p_xs;
    logic signed [PROD_W-1:0]  n_p_yc;
    logic                      r_vb;
    logic                      w_rdy_b;
    logic signed [PROD_W-1:0]  r_p_xc;
    logic signed [PROD_W-1:0]  r_p_ys;
    logic signed [PROD_W-1:0]  r_p_xs;
    logic signed [PROD_W-1:0]  r_p_yc;
    logic signed [COORD_W-1:0] r_px_b;
    logic signed [COORD_W-1:0] r_py_b;

    // stage c: sums rounded to integers
    logic signed [SUM_W-1:0] w_sum_x;
    logic signed [SUM_W-1:0] w_sum_y;
    logic signed [SUM_W-1:0] w_adj_x;
    logic signed [SUM_W-1:0] w_adj_y;
    t_rnd                    n_rnd;
    logic                    r_vc;
    logic                    w_rdy_c;
    t_rnd                    r_rnd;

    always_comb begin
        case (i_crd.quad)
            QUAD_1: begin
                w_c = -i_crd.y;
                w_s = i_crd.x;
            end
            QUAD_2: begin
                w_c = -i_crd.x;
                w_s = -i_crd.y;
            end
            QUAD_3: begin
                w_c = i_crd.y;
                w_s = -i_crd.x;
            end
            default: begin
                w_c = i_crd.x;
                w_s = i_crd.y;
            end
        endcase
    end

    assign w_c16 = (w_c + Q30_RND) >>> Q30_SHR;
    assign w_s16 = (w_s + Q30_RND) >>> Q30_SHR;

    always_comb begin
        if (w_c16 > TRIG_MAX) begin
            n_c = TRIG_W'(TRIG_MAX);
        end else if (w_c16 < TRIG_MIN) begin
            n_c = TRIG_W'(TRIG_MIN);
        end else begin
            n_c = w_c16[TRIG_W-1:0];
        end
        if (w_s16 > TRIG_MAX) begin
            n_s = TRIG_W'(TRIG_MAX);
        end else if (w_s16 < TRIG_MIN) begin
            n_s = TRIG_W'(TRIG_MIN);
        end else begin
            n_s = w_s16[TRIG_W-1:0];
        end
    end

    assign w_rdy_c = !r_vc || i_ready;
    assign w_rdy_b = !r_vb || w_rdy_c;
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_va <= i_valid;
            end
            if (w_rdy_b) begin
                r_vb <= r_va;
            end
            if (w_rdy_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_c     <= n_c;
            r_s     <= n_s;
            r_geo_a <= i_geo;
        end
    end

    assign n_p_xc = r_geo_a.dx * r_c;
    assign n_p_ys = r_geo_a.dy * r_s;
    assign n_p_xs = r_geo_a.dx * r_s;
    assign n_p_yc = r_geo_a.dy * r_c;

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_va) begin
            r_p_xc <= n_p_xc;
            r_p_ys <= n_p_ys;
            r_p_xs <= n_p_xs;
            r_p_yc <= n_p_yc;
            r_px_b <= r_geo_a.px;
            r_py_b <= r_geo_a.py;
        end
    end

    assign w_sum_x = {r_p_xc[PROD_W-1], r_p_xc} - {r_p_ys[PROD_W-1], r_p_ys};
    assign w_sum_y = {r_p_xs[PROD_W-1], r_p_xs} + {r_p_yc[PROD_W-1], r_p_yc};

    // ties away from zero: negative values take one less before the floor shift
    assign w_adj_x = w_sum_x + (w_sum_x[SUM_W-1] ? HALF_NEG : HALF_POS);
    assign w_adj_y = w_sum_y + (w_sum_y[SUM_W-1] ? HALF_NEG : HALF_POS);

    always_comb begin
        n_rnd.rx = w_adj_x[SUM_W-1:FRAC_W];
        n_rnd.ry = w_adj_y[SUM_W-1:FRAC_W];
        n_rnd.px = r_px_b;
        n_rnd.py = r_py_b;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_c && r_vb) begin
            r_rnd <= n_rnd;
        end
    end

    assign o_valid = r_vc;
    assign o_rnd   = r_rnd;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench import rpp_pkg::*;;

    localparam int ROT_STEPS  = CORDIC_STEPS_DEF;
    localparam int TURN_BITS  = ANGLE_BITS_DEF;
    localparam int DRAIN_WAIT = ROT_STEPS + 25;

    typedef struct {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
        logic [ANGLE_W-1:0]        turn_angle;
    } t_point_in;

    typedef struct {
        logic signed [RES_W-1:0] rotated_x;
        logic signed [RES_W-1:0] rotated_y;
    } t_rotated;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    // point_x, point_y, pivot_x, pivot_y, turn_angle, pad
    logic [S_TDATA_W-1:0] s_data = '0;
    logic                 m_ready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    // rotated_x, rotated_y, pad
    logic [M_TDATA_W-1:0] o_m_axis_tdata;

    t_rotated expected_rotations[$];
    int       mismatch_count = 0;
    int       sender_idle_pct = 0;
    int       receiver_idle_pct = 0;

    point_rotation_about_pivot_core #(
        .CORDIC_STEPS(ROT_STEPS),
        .ANGLE_BITS  (TURN_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // arctangent of 2^-k in units of 2^-32 turn
    function automatic longint arctan_step(input int k);
        case (k)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            24: return 64'h00000029;
            25: return 64'h00000014;
            26: return 64'h0000000A;
            27: return 64'h00000005;
            28: return 64'h00000003;
            29: return 64'h00000001;
            30: return 64'h00000001;
            default: return 64'h0;
        endcase
    endfunction

    // q30 -> q16 with half-up rounding, clamped to +-1.0
    function automatic longint trig_to_q16(input longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 65536)
            r = 65536;
        if (r < -65536)
            r = -65536;
        return r;
    endfunction

    // q16 -> integer, ties away from zero
    function automatic longint round_half_away(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 32768) >>> 16;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [RES_W-1:0] clip_result(input longint v);
        if (v > 65535)
            v = 65535;
        if (v < -65536)
            v = -65536;
        return v[RES_W-1:0];
    endfunction

    function automatic t_rotated rotate_about_pivot(input t_point_in p);
        longint     x;
        longint     y;
        longint     z;
        longint     xs;
        longint     ys;
        longint     cos_q16;
        longint     sin_q16;
        longint     dx;
        longint     dy;
        logic [63:0] turn;
        logic [31:0] phase;
        t_rotated   r;
        turn  = 64'(p.turn_angle) & ((64'd1 << TURN_BITS) - 1);
        phase = 32'(turn << (32 - TURN_BITS));
        x = 652032874;
        y = 0;
        z = 64'(phase[29:0]);
        for (int k = 0; k < ROT_STEPS && k < 32; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(k);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(k);
            end
        end
        // quadrant folded in exactly by swapping and negating
        case (phase[31:30])
            QUAD_1: begin
                cos_q16 = -y;
                sin_q16 = x;
            end
            QUAD_2: begin
                cos_q16 = -x;
                sin_q16 = -y;
            end
            QUAD_3: begin
                cos_q16 = y;
                sin_q16 = -x;
            end
            default: begin
                cos_q16 = x;
                sin_q16 = y;
            end
        endcase
        cos_q16 = trig_to_q16(cos_q16);
        sin_q16 = trig_to_q16(sin_q16);
        dx = longint'(p.point_x) - longint'(p.pivot_x);
        dy = longint'(p.point_y) - longint'(p.pivot_y);
        r.rotated_x = clip_result(round_half_away(dx * cos_q16 - dy * sin_q16)
                                  + longint'(p.pivot_x));
        r.rotated_y = clip_result(round_half_away(dx * sin_q16 + dy * cos_q16)
                                  + longint'(p.pivot_y));
        return r;
    endfunction

    function automatic t_point_in make_point(input int px, input int py, input int cx,
                                             input int cy, input int ang);
        t_point_in p;
        p.point_x    = px[COORD_W-1:0];
        p.point_y    = py[COORD_W-1:0];
        p.pivot_x    = cx[COORD_W-1:0];
        p.pivot_y    = cy[COORD_W-1:0];
        p.turn_angle = ang[ANGLE_W-1:0];
        return p;
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(11))
            0: return -15'sd16384;
            1: return 15'sd16383;
            2: return 15'sd0;
            3: return -15'sd1;
            default: return 15'($urandom_range(32767));
        endcase
    endfunction

    function automatic t_point_in random_point();
        t_point_in p;
        p.pivot_x = random_coord();
        p.pivot_y = random_coord();
        if ($urandom_range(4) == 0) begin
            // point close to the pivot: small offsets stress rounding
            p.point_x = p.pivot_x ^ 15'($urandom_range(15));
            p.point_y = p.pivot_y ^ 15'($urandom_range(15));
        end else begin
            p.point_x = random_coord();
            p.point_y = random_coord();
        end
        case ($urandom_range(7))
            0: p.turn_angle = 16'($urandom_range(3)) << 14;
            1: p.turn_angle = (16'($urandom_range(3)) << 14) - 16'd1;
            default: p.turn_angle = 16'($urandom_range(65535));
        endcase
        return p;
    endfunction

    task automatic send_point(input t_point_in p);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0, p.turn_angle, p.pivot_y, p.pivot_x, p.point_y, p.point_x};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        expected_rotations.push_back(rotate_about_pivot(p));
    endtask

    task automatic check_rotation(input logic [M_TDATA_W-1:0] data);
        t_rotated want;
        t_rotated got;
        got.rotated_x = data[16:0];
        got.rotated_y = data[33:17];
        if (expected_rotations.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transfer x=%0d y=%0d", $time,
                     got.rotated_x, got.rotated_y);
        end else begin
            want = expected_rotations.pop_front();
            if (got.rotated_x !== want.rotated_x) begin
                mismatch_count++;
                $display("%0t: rotated_x expected %0d actual %0d", $time,
                         want.rotated_x, got.rotated_x);
            end
            if (got.rotated_y !== want.rotated_y) begin
                mismatch_count++;
                $display("%0t: rotated_y expected %0d actual %0d", $time,
                         want.rotated_y, got.rotated_y);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            check_rotation(o_m_axis_tdata);
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic test_field_extremes();
        send_point(make_point(0, 0, 0, 0, 0));
        send_point(make_point(16383, 16383, -16384, -16384, 16'h2000));
        send_point(make_point(-16384, -16384, 16383, 16383, 16'h2000));
        send_point(make_point(16383, -16384, -16384, 16383, 16'h6000));
        send_point(make_point(-16384, 16383, 16383, -16384, 16'hE000));
        send_point(make_point(-16384, -16384, -16384, -16384, 16'h1234));
        send_point(make_point(16383, 16383, -16384, 16383, 16'hFFFF));
    endtask

    task automatic test_quadrant_angles();
        int angles[10] = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000, 16'h4001,
                           16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
        foreach (angles[k])
            send_point(make_point(1000, -2000, -300, 700, angles[k]));
    endtask

    // cos near one half at 60 and 120 degrees puts unit offsets on a tie
    task automatic test_rounding_ties();
        send_point(make_point(1, 0, 0, 0, 10923));
        send_point(make_point(-1, 0, 0, 0, 10923));
        send_point(make_point(5, 3, 2, 3, 21845));
        send_point(make_point(-7, 0, 0, 0, 21845));
    endtask

    task automatic test_random_points(input int count);
        for (int n = 0; n < count; n++)
            send_point(random_point());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_quadrant_angles();
        test_rounding_ties();

        sender_idle_pct   = 7;
        receiver_idle_pct = 46;
        test_random_points(670);
        sender_idle_pct   = 46;
        receiver_idle_pct = 7;
        test_random_points(670);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_points(660);
        s_valid <= 1'b0;

        while (expected_rotations.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
hw/rtl/rpp_pkg.sv
hw/rtl/rpp_front.sv
hw/rtl/rpp_cordic.sv
hw/rtl/rpp_mix.sv
hw/rtl/point_rotation_about_pivot_core.sv
tb/sv/testbench.sv
